>>> hdl/p1305_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared widths, masks, types and helpers of the Poly1305 tag engine.
// ----------------------------------------------------------------------------
package p1305_pkg;

  localparam int LIMB_W = 26;           // radix 2^26 limbs
  localparam int A0_W   = LIMB_W + 1;   // limb 0 may sit just above 2^26
  localparam int H_W    = 28;           // accumulator plus block limb
  localparam int C_W    = 29;           // r limb or 5 * r limb
  localparam int P_W    = H_W + C_W;    // one partial product
  localparam int S_W    = 60;           // column sum of five products
  localparam int K_W    = S_W - LIMB_W; // column carry
  localparam int N_W    = 40;           // limbs during normalization

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_R_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_R_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_S_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_S_HIGH = 3'd3;

  localparam logic [127:0] CLAMP_MASK = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
  localparam logic [LIMB_W-1:0] LIMB_MASK = {LIMB_W{1'b1}};
  localparam logic [N_W-1:0] N_MASK = {{(N_W - LIMB_W){1'b0}}, LIMB_MASK};

  typedef logic [4:0][N_W-1:0] nlimbs_t;

  // one block handed from the byte collector to the arithmetic core
  typedef struct packed {
    logic [127:0] blk;
    logic         hibit;
    logic         absorb;
    logic         is_last;
  } job_t;

  // finished tag handed from the core to the output buffer
  typedef struct packed {
    logic        push;
    logic [63:0] lo;
    logic [63:0] hi;
  } tag_t;

  // one carry pass over five limbs with the 2^130 = 5 wrap at the end
  function automatic nlimbs_t norm_pass(input nlimbs_t t);
    nlimbs_t v;
    logic [N_W-1:0] c;
    v = t;
    for (int i = 0; i < 4; i++) begin
      v[i+1] = v[i+1] + (v[i] >> LIMB_W);
      v[i]   = v[i] & N_MASK;
    end
    c    = v[4] >> LIMB_W;
    v[4] = v[4] & N_MASK;
    v[0] = v[0] + (c << 2) + c;
    return v;
  endfunction

endpackage

>>> hdl/p1305_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_if
// Valid/ready channels of the Poly1305 tag engine: message bytes in, tag out.
// ----------------------------------------------------------------------------
interface p1305_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface p1305_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_word;
  logic        tag_last;

  modport source (output valid, tag_word, tag_last, input ready);
  modport sink (input valid, tag_word, tag_last, output ready);
endinterface

>>> hdl/p1305_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p1305_core
// Block multiply by r modulo 2^130-5, carry normalization and tag finish.
// ----------------------------------------------------------------------------
module p1305_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  p1305_pkg::job_t    job,
  output logic               job_take,
  input  logic [63:0]        r_low,
  input  logic [63:0]        r_high,
  input  logic [63:0]        s_low,
  input  logic [63:0]        s_high,
  input  logic               tag_ready,
  output p1305_pkg::tag_t    tag
);

  localparam int LW  = p1305_pkg::LIMB_W;
  localparam int HW  = p1305_pkg::H_W;
  localparam int CW  = p1305_pkg::C_W;
  localparam int PW  = p1305_pkg::P_W;
  localparam int SW  = p1305_pkg::S_W;
  localparam int KW  = p1305_pkg::K_W;
  localparam int NW  = p1305_pkg::N_W;
  localparam int AW  = p1305_pkg::A0_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_WRAP  = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_FIN_G = 3'd4;
  localparam logic [2:0] S_FIN_S = 3'd5;
  localparam logic [2:0] S_FIN_O = 3'd6;

  localparam logic [2:0] MUL_LAST = 3'd6;   // products 0..4, sums 1..5, carries 2..6
  localparam logic [2:0] COL_LAG  = 3'd2;
  localparam logic [HW-1:0] G_MASK = HW'(p1305_pkg::LIMB_MASK);

  // control
  logic [2:0]             state_r, state_nxt;
  logic [2:0]             cyc_r;
  logic                   norm_cnt_r;
  logic                   is_last_r;
  logic [AW-1:0]          acc0_r;
  logic [4:1][LW-1:0]     acc_r;

  // datapath
  logic [4:0][HW-1:0]     h_r;
  logic [4:0][CW-1:0]     coef_r;
  logic [3:0][LW-1:0]     rfeed_r;
  logic [4:0][PW-1:0]     p_r;
  logic [SW-1:0]          psum_r;
  logic [KW-1:0]          carry_r;
  logic [4:0][LW-1:0]     d_r;
  p1305_pkg::nlimbs_t     n_r;
  logic [63:0]            lo_r, hi_r;
  logic [64:0]            sum_lo_r;
  logic [63:0]            hi_sum_r;

  logic [127:0]           key;
  logic [4:0][LW-1:0]     rl;
  logic [4:1][CW-1:0]     q;
  logic [4:0][LW-1:0]     bl;
  logic [4:0][HW-1:0]     h_new;
  logic [4:0][PW-1:0]     prod;
  logic [SW-1:0]          psum_c;
  logic [SW-1:0]          col_sum;
  logic [2:0]             col;
  p1305_pkg::nlimbs_t     n_wrap;
  p1305_pkg::nlimbs_t     n_pass;
  logic [4:0][HW-1:0]     g;
  logic                   g_wrap;
  logic [AW-1:0]          fh0;
  logic [4:1][LW-1:0]     fh;
  logic [63:0]            lo_c, hi_c;

  assign job_take = (state_r == S_IDLE) && job_valid;

  // clamped r in limbs, and 5 * r for the wrapped terms
  always_comb begin
    key   = {r_high, r_low} & p1305_pkg::CLAMP_MASK;
    rl[0] = key[25:0];
    rl[1] = key[51:26];
    rl[2] = key[77:52];
    rl[3] = key[103:78];
    rl[4] = LW'(key[127:104]);
    for (int i = 1; i < 5; i++) begin
      q[i] = (CW'(rl[i]) << 2) + CW'(rl[i]);
    end
  end

  // block limbs added onto the accumulator
  always_comb begin
    bl[0] = job.blk[25:0];
    bl[1] = job.blk[51:26];
    bl[2] = job.blk[77:52];
    bl[3] = job.blk[103:78];
    bl[4] = {1'b0, job.hibit, job.blk[127:104]};
    h_new[0] = HW'(acc0_r) + HW'(bl[0]);
    for (int i = 1; i < 5; i++) begin
      h_new[i] = HW'(acc_r[i]) + HW'(bl[i]);
    end
  end

  // one column of the schoolbook product per cycle
  always_comb begin
    psum_c = '0;
    for (int i = 0; i < 5; i++) begin
      prod[i] = h_r[i] * coef_r[i];
      psum_c  = psum_c + SW'(p_r[i]);
    end
    col     = cyc_r - COL_LAG;
    col_sum = psum_r + SW'(carry_r);
  end

  always_comb begin
    n_wrap[0] = NW'(d_r[0]) + (NW'(carry_r) << 2) + NW'(carry_r);
    for (int i = 1; i < 5; i++) begin
      n_wrap[i] = NW'(d_r[i]);
    end
    n_pass = p1305_pkg::norm_pass(n_r);
  end

  // final reduction: take h + 5 - 2^130 when h + 5 reaches 2^130
  always_comb begin
    g[0] = HW'(acc0_r) + HW'(3'd5);
    for (int i = 0; i < 4; i++) begin
      g[i+1] = HW'(acc_r[i+1]) + (g[i] >> LW);
      g[i]   = g[i] & G_MASK;
    end
    g_wrap = |g[4][HW-1:LW];
    fh0    = g_wrap ? AW'(g[0][LW-1:0]) : acc0_r;
    for (int i = 1; i < 5; i++) begin
      fh[i] = g_wrap ? g[i][LW-1:0] : acc_r[i];
    end
    lo_c = 64'(fh0) | (64'(fh[1]) << 26) | (64'(fh[2]) << 52);
    hi_c = 64'(fh[2][25:12]) | (64'(fh[3]) << 14) | (64'(fh[4]) << 40);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          state_nxt = job.absorb ? S_MUL : S_FIN_G;
        end
      end
      S_MUL: begin
        if (cyc_r == MUL_LAST) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP:  state_nxt = S_NORM;
      S_NORM: begin
        if (norm_cnt_r) begin
          state_nxt = is_last_r ? S_FIN_G : S_IDLE;
        end
      end
      S_FIN_G: state_nxt = S_FIN_S;
      S_FIN_S: state_nxt = S_FIN_O;
      S_FIN_O: begin
        if (tag_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cyc_r      <= '0;
      norm_cnt_r <= 1'b0;
      is_last_r  <= 1'b0;
      acc0_r     <= '0;
      acc_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (job_take) begin
        is_last_r <= job.is_last;
        cyc_r     <= '0;
      end
      if (state_r == S_MUL) begin
        cyc_r <= cyc_r + 3'd1;
      end
      if (state_r == S_WRAP) begin
        norm_cnt_r <= 1'b0;
      end
      if (state_r == S_NORM) begin
        norm_cnt_r <= 1'b1;
        if (norm_cnt_r) begin
          acc0_r <= AW'(n_pass[0]);
          for (int i = 1; i < 5; i++) begin
            acc_r[i] <= n_pass[i][LW-1:0];
          end
        end
      end
      if ((state_r == S_FIN_O) && tag_ready) begin
        acc0_r <= '0;
        acc_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take && job.absorb) begin
      h_r       <= h_new;
      coef_r[0] <= CW'(rl[0]);
      coef_r[1] <= q[4];
      coef_r[2] <= q[3];
      coef_r[3] <= q[2];
      coef_r[4] <= q[1];
      for (int i = 0; i < 4; i++) begin
        rfeed_r[i] <= rl[i+1];
      end
      carry_r <= '0;
    end
    if (state_r == S_MUL) begin
      p_r    <= prod;
      psum_r <= psum_c;
      // next column: coefficients slide one term, next r limb enters at term 0
      coef_r[0] <= CW'(rfeed_r[0]);
      for (int i = 1; i < 5; i++) begin
        coef_r[i] <= coef_r[i-1];
      end
      for (int i = 0; i < 3; i++) begin
        rfeed_r[i] <= rfeed_r[i+1];
      end
      if (cyc_r >= COL_LAG) begin
        d_r[col] <= col_sum[LW-1:0];
        carry_r  <= col_sum[SW-1:LW];
      end
    end
    if (state_r == S_WRAP) begin
      n_r <= n_wrap;
    end
    if ((state_r == S_NORM) && !norm_cnt_r) begin
      n_r <= n_pass;
    end
    if (state_r == S_FIN_G) begin
      lo_r <= lo_c;
      hi_r <= hi_c;
    end
    if (state_r == S_FIN_S) begin
      sum_lo_r <= {1'b0, lo_r} + {1'b0, s_low};
      hi_sum_r <= hi_r + s_high;
    end
  end

  assign tag.push = (state_r == S_FIN_O) && tag_ready;
  assign tag.lo   = sum_lo_r[63:0];
  assign tag.hi   = hi_sum_r + 64'(sum_lo_r[64]);

  a_absorb_start: assert property (@(posedge clk) disable iff (!rst_n)
    job_take && job.absorb |=> (state_r == S_MUL) && (cyc_r == 3'd0))
    else $error("absorb job did not start the multiply");

  a_mul_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (cyc_r <= MUL_LAST))
    else $error("multiply column counter ran past its last column");

  a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN_O) && !tag_ready |=>
      (state_r == S_FIN_O) && $stable(sum_lo_r) && $stable(hi_sum_r))
    else $error("finished tag changed while the output buffer was full");

endmodule

>>> hdl/poly1305_mac_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly1305_mac_engine_unit
// Byte-serial Poly1305 one-time authenticator producing a 128-bit tag.
// ----------------------------------------------------------------------------
// Usage
//   Write the 32-byte key through cfg_* (r low/high, s low/high) while idle.
//   Message bytes enter on in_ch, one per transfer; byte_valid = 0 with
//   last = 1 closes a message whose bytes were already sent. The tag leaves
//   on out_ch as two 64-bit words, bytes 0..7 first, tag_last on the second.
//   Throughput: one byte per cycle while in_ch.ready is high. A full 16-byte
//   block goes to the multiply core, where five 28x29 multipliers evaluate
//   one product column per cycle, then carry passes follow; the next
//   block's bytes are collected meanwhile, and in_ch.ready drops only while
//   a collected block waits for the core to take it.
//   A last transfer that pads a block sends its tag through the multiply and
//   carry states first; one that closes with no bytes held goes to the finish.
//   The tag waits in a two-word output buffer; while out_ch stalls, input
//   bytes keep flowing until a collected block waits for the core.
//   Reset clears the accumulator, fill count and key registers; no pass
//   over the block buffer is needed.
// ----------------------------------------------------------------------------
module poly1305_mac_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  p1305_in_if.sink                          in_ch,
  p1305_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [p1305_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [63:0]                       cfg_data
);

  logic [63:0]        r_low_r, r_high_r, s_low_r, s_high_r;

  logic [15:0][7:0]   buf_r, buf_nxt;
  logic [3:0]         fill_r;
  logic               job_valid_r;
  p1305_pkg::job_t    job_r, job_nxt;
  logic               job_take;

  logic               in_xfer;
  logic [4:0]         cnt_new;
  logic               full;
  logic [3:0]         n_held;
  logic [15:0][7:0]   padded;
  logic               make_job;

  p1305_pkg::tag_t    tag;
  logic               tag_ready;
  logic [1:0]         out_pend_r;
  logic [63:0]        out_lo_r, out_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r  <= '0;
      r_high_r <= '0;
      s_low_r  <= '0;
      s_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        p1305_pkg::REG_R_LOW:  r_low_r  <= cfg_data;
        p1305_pkg::REG_R_HIGH: r_high_r <= cfg_data;
        p1305_pkg::REG_S_LOW:  s_low_r  <= cfg_data;
        p1305_pkg::REG_S_HIGH: s_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte collector
  assign in_ch.ready = !job_valid_r || job_take;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    buf_nxt = buf_r;
    if (in_ch.byte_valid) begin
      buf_nxt[fill_r] = in_ch.data_byte;
    end
    cnt_new = {1'b0, fill_r} + 5'(in_ch.byte_valid);
    full    = cnt_new[4];
    n_held  = cnt_new[3:0];
    // partial block: held bytes, then 0x01, then zeros
    for (int i = 0; i < 16; i++) begin
      if (4'(i) < n_held) begin
        padded[i] = buf_nxt[i];
      end else if (4'(i) == n_held) begin
        padded[i] = 8'h01;
      end else begin
        padded[i] = 8'h00;
      end
    end
    job_nxt.blk     = full ? buf_nxt : padded;
    job_nxt.hibit   = full;
    job_nxt.absorb  = full || (n_held != 4'd0);
    job_nxt.is_last = in_ch.last;
    make_job        = in_xfer && (full || in_ch.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      job_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        fill_r <= (full || in_ch.last) ? 4'd0 : n_held;
      end
      if (make_job) begin
        job_valid_r <= 1'b1;
      end else if (job_take) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      buf_r <= buf_nxt;
    end
    if (make_job) begin
      job_r <= job_nxt;
    end
  end

  p1305_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid_r),
    .job       (job_r),
    .job_take  (job_take),
    .r_low     (r_low_r),
    .r_high    (r_high_r),
    .s_low     (s_low_r),
    .s_high    (s_high_r),
    .tag_ready (tag_ready),
    .tag       (tag)
  );

  // two-word output buffer, count of words still to transfer
  assign tag_ready       = (out_pend_r == 2'd0);
  assign out_ch.valid    = (out_pend_r != 2'd0);
  assign out_ch.tag_word = out_pend_r[1] ? out_lo_r : out_hi_r;
  assign out_ch.tag_last = (out_pend_r == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_pend_r <= 2'd0;
    end else if (tag.push) begin
      out_pend_r <= 2'd2;
    end else if (out_ch.valid && out_ch.ready) begin
      out_pend_r <= out_pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.push) begin
      out_lo_r <= tag.lo;
      out_hi_r <= tag.hi;
    end
  end

  a_tag_first: assert property (@(posedge clk) disable iff (!rst_n)
    tag.push |=> out_ch.valid && !out_ch.tag_last)
    else $error("tag written but first word not presented");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && !job_take |=> job_valid_r && $stable(job_r))
    else $error("pending block lost before the core took it");

  a_tag_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.tag_last |=> !out_ch.valid)
    else $error("output buffer not empty after the second tag word");

endmodule

>>> tb/sv/tb_poly1305_mac_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_poly1305_mac_engine_unit
// Self-checking bench for the byte-serial Poly1305 tag engine. Bytes go in
// through the input channel, and both sides stall at random. A limb-level
// model of the accumulator predicts the two tag words of every message. The
// key is changed between messages only, including the all-zero and all-ones
// extremes and writes to unused register slots. A short table of directed
// messages comes first, and random messages of random length follow it.
// ----------------------------------------------------------------------------
module tb_poly1305_mac_engine_unit;

  localparam int          IDX_W        = p1305_pkg::CFG_IDX_W;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          ITEM_TARGET  = 1250;
  localparam logic [63:0] ALL_ONES64   = '1;
  localparam logic [63:0] LIMB_M       = 64'h0000_0000_03ff_ffff;
  localparam logic [63:0] HIGH_BIT     = 64'h0000_0000_0100_0000;

  typedef logic [4:0][63:0] wide_limbs_t;

  typedef enum logic [1:0] {KEYS_RESET, KEYS_S_ONLY, KEYS_ALL_ONES} key_set_t;

  typedef struct packed {
    key_set_t    key_set;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic        typed;
    logic [63:0] tag_lo;
    logic [63:0] tag_hi;
  } dir_row_t;

  typedef struct packed {
    logic [63:0] tag_word;
    logic        tag_last;
  } tag_due_t;

  // r = 0 makes every tag equal to s; the full block on a last byte with the
  // all-ones key goes to the predictor
  localparam dir_row_t DIR_ROWS [22] = '{
    '{KEYS_RESET,    8'h00, 1'b0, 1'b1, 1'b1, 64'h0, 64'h0},
    '{KEYS_RESET,    8'h5a, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_RESET,    8'hff, 1'b1, 1'b1, 1'b1, 64'h0, 64'h0},
    '{KEYS_S_ONLY,   8'h00, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_S_ONLY,   8'hff, 1'b1, 1'b1, 1'b1, ALL_ONES64, ALL_ONES64},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'hff, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
    '{KEYS_ALL_ONES, 8'h00, 1'b0, 1'b1, 1'b1, ALL_ONES64, ALL_ONES64}
  };

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_index;
  logic [63:0]          cfg_data;

  p1305_in_if  in_ch ();
  p1305_out_if out_ch ();

  poly1305_mac_engine_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mac state as the block should hold it
  logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
  logic [31:0] acc_limb [5];
  logic [7:0]  blk_buf [16];
  int unsigned fill_cnt;

  tag_due_t    tags_due [$];
  int unsigned mismatches;
  int unsigned items_fed;
  int unsigned cycle_cnt;
  bit          in_calm;
  bit          out_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap(input bit calm);
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_key_word();
    case ($urandom_range(0, 5))
      0:       return 64'h0;
      1:       return ALL_ONES64;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // three carry passes, top carry wraps around times 5
  function automatic wide_limbs_t fold_limbs(input wide_limbs_t t);
    wide_limbs_t v;
    logic [63:0] c;
    v = t;
    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 4; i++) begin
        v[i+1] = v[i+1] + (v[i] >> 26);
        v[i]   = v[i] & LIMB_M;
      end
      c    = v[4] >> 26;
      v[4] = v[4] & LIMB_M;
      v[0] = v[0] + c * 5;
    end
    return v;
  endfunction

  // acc = (acc + block) * clamped r mod 2^130 - 5, in 26-bit limbs
  function automatic void absorb_block(input logic [63:0] hibit);
    logic [63:0] w [4];
    logic [63:0] k0, k1, k2, k3;
    wide_limbs_t r, q, h, d;
    for (int i = 0; i < 4; i++)
      w[i] = {32'h0, blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
    k0 = {32'h0, key_r_lo[31:0] & 32'h0fff_ffff};
    k1 = {32'h0, key_r_lo[63:32] & 32'h0fff_fffc};
    k2 = {32'h0, key_r_hi[31:0] & 32'h0fff_fffc};
    k3 = {32'h0, key_r_hi[63:32] & 32'h0fff_fffc};
    r[0] = k0 & LIMB_M;
    r[1] = ((k0 >> 26) | (k1 << 6)) & LIMB_M;
    r[2] = ((k1 >> 20) | (k2 << 12)) & LIMB_M;
    r[3] = ((k2 >> 14) | (k3 << 18)) & LIMB_M;
    r[4] = k3 >> 8;
    for (int i = 0; i < 5; i++) q[i] = r[i] * 5;
    h[0] = {32'h0, acc_limb[0]} + (w[0] & LIMB_M);
    h[1] = {32'h0, acc_limb[1]} + (((w[0] >> 26) | (w[1] << 6)) & LIMB_M);
    h[2] = {32'h0, acc_limb[2]} + (((w[1] >> 20) | (w[2] << 12)) & LIMB_M);
    h[3] = {32'h0, acc_limb[3]} + (((w[2] >> 14) | (w[3] << 18)) & LIMB_M);
    h[4] = {32'h0, acc_limb[4]} + ((w[3] >> 8) | hibit);
    // wrapped columns use 5 * r
    for (int j = 0; j < 5; j++) begin
      d[j] = '0;
      for (int i = 0; i < 5; i++)
        d[j] = d[j] + h[i] * ((i <= j) ? r[(j - i + 5) % 5] : q[(j - i + 5) % 5]);
    end
    d = fold_limbs(d);
    for (int i = 0; i < 5; i++) acc_limb[i] = d[i][31:0];
  endfunction

  // returns 1 when the byte closes a message and the tag is due
  function automatic bit take_mac_byte(input logic [7:0] b, input logic bv,
                                       input logic lst, output logic [63:0] t_lo,
                                       output logic [63:0] t_hi);
    wide_limbs_t h, g;
    logic [63:0] lo, hi, sum_lo;
    t_lo = '0;
    t_hi = '0;
    if (bv) begin
      blk_buf[fill_cnt % 16] = b;
      fill_cnt = (fill_cnt + 1) % 32;
      if (fill_cnt >= 16) begin
        absorb_block(HIGH_BIT);
        fill_cnt = 0;
      end
    end
    if (!lst) return 1'b0;
    if (fill_cnt > 0) begin
      blk_buf[fill_cnt] = 8'h01;
      for (int i = fill_cnt + 1; i < 16; i++) blk_buf[i] = 8'h00;
      absorb_block(64'h0);
    end
    for (int i = 0; i < 5; i++) h[i] = {32'h0, acc_limb[i]};
    // subtract p when acc + 5 reaches 2^130
    g[0] = h[0] + 5;
    for (int i = 0; i < 4; i++) begin
      g[i+1] = h[i+1] + (g[i] >> 26);
      g[i]   = g[i] & LIMB_M;
    end
    if ((g[4] >> 26) != 0) begin
      g[4] = g[4] & LIMB_M;
      h    = g;
    end
    lo     = h[0] | (h[1] << 26) | (h[2] << 52);
    hi     = (h[2] >> 12) | (h[3] << 14) | (h[4] << 40);
    sum_lo = lo + key_s_lo;
    t_lo   = sum_lo;
    t_hi   = hi + key_s_hi + {63'h0, sum_lo < lo};
    for (int i = 0; i < 5; i++) acc_limb[i] = '0;
    for (int i = 0; i < 16; i++) blk_buf[i] = '0;
    fill_cnt = 0;
    return 1'b1;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic bv, input logic lst,
                           input bit typed, input logic [63:0] typed_lo,
                           input logic [63:0] typed_hi);
    int unsigned gap;
    logic [63:0] p_lo, p_hi;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.byte_valid <= bv;
    in_ch.last       <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (take_mac_byte(b, bv, lst, p_lo, p_hi)) begin
      tags_due.push_back('{tag_word: typed ? typed_lo : p_lo, tag_last: 1'b0});
      tags_due.push_back('{tag_word: typed ? typed_hi : p_hi, tag_last: 1'b1});
    end
  endtask

  // drop valid, let every tag drain, then give the core time to go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tags_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      p1305_pkg::REG_R_LOW:  key_r_lo = val;
      p1305_pkg::REG_R_HIGH: key_r_hi = val;
      p1305_pkg::REG_S_LOW:  key_s_lo = val;
      p1305_pkg::REG_S_HIGH: key_s_hi = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_keys(input logic [63:0] rl, input logic [63:0] rh,
                           input logic [63:0] sl, input logic [63:0] sh);
    // slots above the key registers must not disturb anything
    if ($urandom_range(0, 1) == 0)
      put_reg(IDX_W'(p1305_pkg::REG_S_HIGH + 1 + $urandom_range(0, 3)),
              {$urandom, $urandom});
    put_reg(p1305_pkg::REG_R_LOW, rl);
    put_reg(p1305_pkg::REG_R_HIGH, rh);
    put_reg(p1305_pkg::REG_S_LOW, sl);
    put_reg(p1305_pkg::REG_S_HIGH, sh);
    cfg_we <= 1'b0;
  endtask

  task automatic send_message();
    int unsigned len;
    bit lone_close;
    case ($urandom_range(0, 9))
      0:       len = 0;
      1:       len = 16 * $urandom_range(1, 3);
      2:       len = 16 * $urandom_range(1, 2) - 1 + 2 * $urandom_range(0, 1);
      3:       len = $urandom_range(41, 100);
      default: len = $urandom_range(1, 40);
    endcase
    lone_close = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(pick_byte(), 1'b0, 1'b0, 1'b0, '0, '0);
      send_item(pick_byte(), 1'b1, !lone_close && (n == len - 1), 1'b0, '0, '0);
      items_fed++;
    end
    if (lone_close) begin
      send_item(pick_byte(), 1'b0, 1'b1, 1'b0, '0, '0);
      items_fed++;
    end
  endtask

  // tag side: random back-pressure and the compare against the oldest tag due
  initial begin
    tag_due_t due;
    int unsigned out_hold;
    out_hold     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (tags_due.size() == 0) begin
          $error("tag_word: expected none, got %h", out_ch.tag_word);
          mismatches++;
        end else begin
          due = tags_due.pop_front();
          if (out_ch.tag_word !== due.tag_word) begin
            $error("tag_word: expected %h, got %h", due.tag_word, out_ch.tag_word);
            mismatches++;
          end
          if (out_ch.tag_last !== due.tag_last) begin
            $error("tag_last: expected %0d, got %0d", due.tag_last, out_ch.tag_last);
            mismatches++;
          end
        end
        out_hold = draw_gap(out_calm);
        out_ch.ready <= (out_hold == 0);
      end else if (out_hold != 0) begin
        out_hold--;
        out_ch.ready <= (out_hold == 0);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_poly1305_mac_engine_unit: errors");
    $finish;
  end

  initial begin
    int unsigned n_msgs;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.byte_valid <= 1'b0;
    in_ch.last       <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= p1305_pkg::REG_R_LOW;
    cfg_data         <= '0;
    mismatches = 0;
    items_fed  = 0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    key_r_lo   = '0;
    key_r_hi   = '0;
    key_s_lo   = '0;
    key_s_hi   = '0;
    for (int i = 0; i < 5; i++) acc_limb[i] = '0;
    for (int i = 0; i < 16; i++) blk_buf[i] = '0;
    fill_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first row checks the reset key with no write at all
    foreach (DIR_ROWS[n]) begin
      if (n > 0 && DIR_ROWS[n].key_set != DIR_ROWS[n-1].key_set) begin
        settle();
        case (DIR_ROWS[n].key_set)
          KEYS_RESET:  load_keys('0, '0, '0, '0);
          KEYS_S_ONLY: load_keys('0, '0, ALL_ONES64, ALL_ONES64);
          default:     load_keys(ALL_ONES64, ALL_ONES64, ALL_ONES64, ALL_ONES64);
        endcase
      end
      send_item(DIR_ROWS[n].data_byte, DIR_ROWS[n].byte_valid, DIR_ROWS[n].last,
                DIR_ROWS[n].typed, DIR_ROWS[n].tag_lo, DIR_ROWS[n].tag_hi);
    end

    while (items_fed < ITEM_TARGET) begin
      settle();
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      load_keys(pick_key_word(), pick_key_word(), pick_key_word(), pick_key_word());
      n_msgs = $urandom_range(1, 4);
      repeat (n_msgs) send_message();
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_poly1305_mac_engine_unit: clean");
    end else begin
      $display("tb_poly1305_mac_engine_unit: errors");
    end
    $finish;
  end

endmodule
